// ----- hw/rtl/mse_pkg.sv -----
// Package of the merge sort engine: data width and the controller state type.
// Used by merge_sort_engine, mse_checker and tb; depends on nothing.
package mse_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic [4:0] {
    S_FILL   = 5'b00001,
    S_SETUP  = 5'b00010,
    S_MERGE  = 5'b00100,
    S_OUT_RD = 5'b01000,
    S_OUT    = 5'b10000
  } state_t;

endpackage

// ----- hw/rtl/merge_sort_engine.sv -----
// Merge sort engine: collects a set of signed values, sorts them by bottom-up
// merge passes between two ping-pong memory banks, and streams them out.
// Depends on mse_pkg (scoped names).
//
//  channel  | dir | signals                          | request
//  ---------+-----+----------------------------------+-----------------------------
//  input    | in  | s_tvalid s_tready s_tdata s_tlast | one value; s_tlast ends set
//  output   | out | m_tvalid m_tready m_tdata m_tlast | one sorted value; m_tlast on
//           |     | m_tuser                          | final one, m_tuser overflow
//
// Flow: the input stores one value per accepted request. A set of n values
// then goes through ceil(log2 n) merge passes; each pass spends a setup step
// per run pair (the registered reads of the two-port source bank require it)
// and a merge step per element. A readout start step then precedes the
// results, one per output request.
// Reset clears the controller, the fill count and the overflow flag; the banks
// keep their contents and only written entries are ever used.
// s_tready is low from the last input request until the final result is taken;
// a stalled result holds its value.
module merge_sort_engine #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [mse_pkg::VALUE_W-1:0] s_tdata,   // [31:0] value
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [mse_pkg::VALUE_W-1:0] m_tdata,   // [31:0] sorted_value
  output logic                       m_tlast,
  output logic [0:0]                 m_tuser     // [0] overflow
);

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int PW = CW + 1;
  localparam int DW = mse_pkg::VALUE_W;

  // Two banks: bank A takes the incoming set; passes alternate source and
  // destination between A and B.
  logic [DW-1:0] mem_a [MAX_ELEMENTS];
  logic [DW-1:0] mem_b [MAX_ELEMENTS];
  logic [DW-1:0] rd0_a, rd1_a, rd0_b, rd1_b;

  mse_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic          dropped, dropped_next;
  logic          src_sel, src_sel_next;
  logic [PW-1:0] width, width_next;
  logic [PW-1:0] lo, lo_next;
  logic [PW-1:0] mid, mid_next;
  logic [PW-1:0] hi, hi_next;
  logic [PW-1:0] a_ptr, a_ptr_next;
  logic [PW-1:0] b_ptr, b_ptr_next;
  logic [PW-1:0] k_ptr, k_ptr_next;
  logic [CW-1:0] idx, idx_next;

  // memory controls
  logic          we_a, we_b, rd_en;
  logic [AW-1:0] wr_addr, rd_addr0, rd_addr1;
  logic [DW-1:0] wr_data;

  logic          in_req, out_req;
  logic [DW-1:0] head_a, head_b;
  logic          take_a;

  assign in_req  = s_tvalid && s_tready;
  assign out_req = m_tvalid && m_tready;

  // Heads of the two runs come from the source bank.
  assign head_a = src_sel ? rd0_b : rd0_a;
  assign head_b = src_sel ? rd1_b : rd1_a;
  assign take_a = (a_ptr < mid) && ((b_ptr >= hi) || ($signed(head_a) <= $signed(head_b)));

  always_comb begin
    logic          full;
    logic [CW-1:0] n_new;
    logic [PW-1:0] n_ext;
    logic [PW-1:0] lo_w, lo_2w, lo_step, width_dbl;

    full      = (count == CW'(MAX_ELEMENTS));
    n_new     = full ? count : count + CW'(1);
    n_ext     = PW'(count);
    lo_w      = lo + width;
    lo_2w     = lo + (width << 1);
    lo_step   = lo + (width << 1);
    width_dbl = width << 1;

    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    src_sel_next = src_sel;
    width_next   = width;
    lo_next      = lo;
    mid_next     = mid;
    hi_next      = hi;
    a_ptr_next   = a_ptr;
    b_ptr_next   = b_ptr;
    k_ptr_next   = k_ptr;
    idx_next     = idx;

    we_a     = 1'b0;
    we_b     = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = count[AW-1:0];
    wr_data  = s_tdata;
    rd_addr0 = a_ptr[AW-1:0];
    rd_addr1 = b_ptr[AW-1:0];

    case (state)
      mse_pkg::S_FILL: begin
        if (in_req) begin
          // store while there is room, otherwise drop and flag
          if (!full) begin
            we_a       = 1'b1;
            count_next = n_new;
          end else begin
            dropped_next = 1'b1;
          end
          if (s_tlast) begin
            src_sel_next = 1'b0;
            width_next   = PW'(1);
            lo_next      = '0;
            idx_next     = '0;
            state_next   = (n_new > CW'(1)) ? mse_pkg::S_SETUP : mse_pkg::S_OUT_RD;
          end
        end
      end

      mse_pkg::S_SETUP: begin
        // clip the run pair to the set and fetch both heads
        mid_next   = (lo_w > n_ext) ? n_ext : lo_w;
        hi_next    = (lo_2w > n_ext) ? n_ext : lo_2w;
        a_ptr_next = lo;
        b_ptr_next = mid_next;
        k_ptr_next = lo;
        rd_addr0   = a_ptr_next[AW-1:0];
        rd_addr1   = b_ptr_next[AW-1:0];
        rd_en      = 1'b1;
        state_next = mse_pkg::S_MERGE;
      end

      mse_pkg::S_MERGE: begin
        // write the smaller head, advance its run and refetch
        we_a       = src_sel;
        we_b       = !src_sel;
        wr_addr    = k_ptr[AW-1:0];
        wr_data    = take_a ? head_a : head_b;
        a_ptr_next = a_ptr + PW'(take_a);
        b_ptr_next = b_ptr + PW'(!take_a);
        k_ptr_next = k_ptr + PW'(1);
        rd_addr0   = a_ptr_next[AW-1:0];
        rd_addr1   = b_ptr_next[AW-1:0];
        rd_en      = 1'b1;
        if (k_ptr_next == hi) begin
          if (lo_step >= n_ext) begin
            src_sel_next = !src_sel;
            width_next   = width_dbl;
            lo_next      = '0;
            state_next   = (width_dbl >= n_ext) ? mse_pkg::S_OUT_RD : mse_pkg::S_SETUP;
          end else begin
            lo_next    = lo_step;
            state_next = mse_pkg::S_SETUP;
          end
        end
      end

      mse_pkg::S_OUT_RD: begin
        rd_addr0   = idx[AW-1:0];
        rd_en      = 1'b1;
        state_next = mse_pkg::S_OUT;
      end

      mse_pkg::S_OUT: begin
        if (out_req) begin
          if (m_tlast) begin
            count_next   = '0;
            dropped_next = 1'b0;
            state_next   = mse_pkg::S_FILL;
          end else begin
            idx_next = idx + CW'(1);
            rd_addr0 = idx_next[AW-1:0];
            rd_en    = 1'b1;
          end
        end
      end

      default: begin
        state_next = mse_pkg::S_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mse_pkg::S_FILL;
      count   <= '0;
      dropped <= 1'b0;
      src_sel <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
      src_sel <= src_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    width <= width_next;
    lo    <= lo_next;
    mid   <= mid_next;
    hi    <= hi_next;
    a_ptr <= a_ptr_next;
    b_ptr <= b_ptr_next;
    k_ptr <= k_ptr_next;
    idx   <= idx_next;
  end

  // bank A: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd0_a <= mem_a[rd_addr0];
      rd1_a <= mem_a[rd_addr1];
    end
  end

  // bank B: one write, two registered reads
  always_ff @(posedge clk) begin
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd0_b <= mem_b[rd_addr0];
      rd1_b <= mem_b[rd_addr1];
    end
  end

  assign s_tready   = (state == mse_pkg::S_FILL);
  assign m_tvalid   = (state == mse_pkg::S_OUT);
  assign m_tdata    = head_a;
  assign m_tlast    = (({1'b0, idx} + PW'(1)) == {1'b0, count});
  assign m_tuser[0] = dropped;

endmodule

// ----- hw/rtl/mse_checker.sv -----
// Port-level checker of the merge sort engine and its bind into merge_sort_engine.
// Depends on mse_pkg (scoped names) and merge_sort_engine.
module mse_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [mse_pkg::VALUE_W-1:0] s_tdata,
  input logic                       s_tlast,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [mse_pkg::VALUE_W-1:0] m_tdata,
  input logic                       m_tlast,
  input logic [0:0]                 m_tuser
);

  // never take input while results are on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready while a result is offered");

  // closing input request stops intake for the sort
  a_last_in_closes: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("input still ready after the last request");

  // final result taken: back to collecting
  a_last_out_reopens: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
    else $error("engine did not return to intake after the final result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=>
      (m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
    else $error("stalled result changed");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (.*);

// ----- tb/sv/tb.sv -----
// Testbench of merge_sort_engine: directed sets from a table, then random sets,
// every sorted value checked against the table's known result or a local sorting predictor.
// Depends on mse_pkg and merge_sort_engine from hw/rtl.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ELEMENTS = 64;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 600;
  localparam int LIMIT_CYCLES = 200000;

  typedef logic signed [mse_pkg::VALUE_W-1:0] value_t;

  localparam value_t V_MIN = value_t'(32'h8000_0000);
  localparam value_t V_MAX = value_t'(32'h7FFF_FFFF);

  // one expected output request
  typedef struct {
    value_t value;
    logic   last;
    logic   ovf;
  } sorted_item_t;

  // one directed input request; typed rows carry a known single-element result
  typedef struct {
    value_t value;
    logic   last;
    logic   typed;
    value_t exp_value;
  } stim_row_t;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  value_t       s_tdata  = '0;      // [31:0] value
  logic         s_tlast  = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  value_t       m_tdata;            // [31:0] sorted_value
  logic         m_tlast;
  logic [0:0]   m_tuser;            // [0] overflow

  logic         hold_off = 1'b0;
  int           mismatches = 0;
  int           results_seen = 0;

  // predictor state: the set collected so far, kept in ascending order
  value_t       set_vals[$];
  logic         set_dropped = 1'b0;
  sorted_item_t pending_sorted[$];

  merge_sort_engine #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always #5 clk = ~clk;

  // Directed table: extremes as single-element sets, whose result is known at a
  // glance, then mixed sets that go through the predictor: extremes and their
  // neighbors together, equal elements, reversed and already sorted input.
  stim_row_t dir_rows [0:22] = '{
    '{V_MIN,              1'b1, 1'b1, V_MIN},
    '{V_MAX,              1'b1, 1'b1, V_MAX},
    '{value_t'(0),        1'b1, 1'b1, value_t'(0)},
    '{value_t'(-1),       1'b1, 1'b1, value_t'(-1)},
    '{V_MAX,              1'b0, 1'b0, '0},
    '{V_MIN,              1'b0, 1'b0, '0},
    '{value_t'(0),        1'b0, 1'b0, '0},
    '{value_t'(-1),       1'b0, 1'b0, '0},
    '{value_t'(1),        1'b0, 1'b0, '0},
    '{value_t'(5),        1'b0, 1'b0, '0},
    '{value_t'(5),        1'b0, 1'b0, '0},
    '{V_MAX - 1,          1'b0, 1'b0, '0},
    '{V_MIN + 1,          1'b0, 1'b0, '0},
    '{value_t'(100),      1'b1, 1'b0, '0},
    '{value_t'(7),        1'b0, 1'b0, '0},
    '{value_t'(7),        1'b1, 1'b0, '0},
    '{value_t'(3),        1'b0, 1'b0, '0},
    '{value_t'(2),        1'b0, 1'b0, '0},
    '{value_t'(1),        1'b0, 1'b0, '0},
    '{value_t'(0),        1'b1, 1'b0, '0},
    '{value_t'(-3),       1'b0, 1'b0, '0},
    '{value_t'(-2),       1'b0, 1'b0, '0},
    '{value_t'(-1),       1'b1, 1'b0, '0}
  };

  // Predictor: store the value in sorted position (after equal ones, so the
  // order stays stable), or flag it dropped once the store is full. On the
  // last request emit the whole set and start a new one.
  function automatic void sort_accept(input value_t v, input logic last,
                                      ref sorted_item_t res[$]);
    int pos;
    pos = 0;
    if (set_vals.size() < MAX_ELEMENTS) begin
      while (pos < set_vals.size() && set_vals[pos] <= v) pos++;
      set_vals.insert(pos, v);
    end else begin
      set_dropped = 1'b1;
    end
    if (last) begin
      foreach (set_vals[i]) begin
        res.push_back('{set_vals[i], logic'(i == set_vals.size() - 1), set_dropped});
      end
      set_vals.delete();
      set_dropped = 1'b0;
    end
  endfunction

  // Gap before a request; a burst set offers back to back.
  function automatic int draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  // Mix of extremes, small values around zero, repeats and full-range values.
  function automatic value_t draw_value(input value_t prev);
    case ($urandom_range(0, 7))
      0:       return V_MIN;
      1:       return V_MAX;
      2:       return value_t'($signed($urandom_range(0, 16)) - 8);
      3:       return prev;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Offer one request after the gap and return at the edge that accepts it.
  // Valid stays high when the next request follows without a gap.
  task automatic drive_item(input value_t v, input logic last, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Receiver: check each accepted output request against the oldest expected
  // one, then draw how long to hold ready low before the next. Occasional
  // bursts keep ready high; hold_off blocks it for the long stall.
  int rx_gap   = 0;
  int rx_burst = 0;

  always @(posedge clk) begin
    sorted_item_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_sorted.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result: actual value %0d last %0b ovf %0b",
                 $time, m_tdata, m_tlast, m_tuser[0]);
      end else begin
        want = pending_sorted.pop_front();
        if (m_tdata !== want.value) begin
          mismatches++;
          $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                   $time, want.value, m_tdata);
        end
        if (m_tlast !== want.last) begin
          mismatches++;
          $display("%0t: final_res mismatch: expected %0b, actual %0b",
                   $time, want.last, m_tlast);
        end
        if (m_tuser[0] !== want.ovf) begin
          mismatches++;
          $display("%0t: overflow mismatch: expected %0b, actual %0b",
                   $time, want.ovf, m_tuser[0]);
        end
      end
      if (rx_burst > 0) begin
        rx_burst--;
        rx_gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        rx_burst = 20;
        rx_gap = 0;
      end else begin
        rx_gap = $urandom_range(0, 15);
      end
    end else if (rx_gap > 0) begin
      rx_gap--;
    end
    m_tready <= !rst && (rx_gap == 0) && !hold_off;
  end

  // Long stall of the receiver, counted here: the sorted set backs up and the
  // engine holds s_tready low while the sender keeps offering the next set.
  initial begin
    wait (results_seen >= 30);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Hard limit on the run.
  initial begin
    #(LIMIT_CYCLES * 10ns);
    $display("[merge_sort_engine] ERROR");
    $finish;
  end

  initial begin
    sorted_item_t res[$];
    sorted_item_t left_item;
    value_t       v;
    value_t       prev;
    int           sent;
    int           set_idx;
    int           len;
    int           waited;
    bit           burst;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (dir_rows[r]) begin
      drive_item(dir_rows[r].value, dir_rows[r].last, draw_gap(1'b0));
      res.delete();
      sort_accept(dir_rows[r].value, dir_rows[r].last, res);
      if (dir_rows[r].typed) begin
        pending_sorted.push_back('{dir_rows[r].exp_value, 1'b1, 1'b0});
      end else begin
        foreach (res[i]) pending_sorted.push_back(res[i]);
      end
    end

    // Random sets: mostly short, one that fills the store exactly and one
    // that overflows it, so the last request itself is dropped.
    sent    = 0;
    set_idx = 0;
    prev    = '0;
    while (sent < RANDOM_ITEMS) begin
      if (set_idx == 3)
        len = MAX_ELEMENTS;
      else if (set_idx == 6)
        len = MAX_ELEMENTS + 1 + $urandom_range(0, 3);
      else
        len = $urandom_range(1, 12);
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < len; k++) begin
        v = draw_value(prev);
        prev = v;
        drive_item(v, logic'(k == len - 1), draw_gap(burst));
        res.delete();
        sort_accept(v, logic'(k == len - 1), res);
        foreach (res[i]) pending_sorted.push_back(res[i]);
        sent++;
      end
      set_idx++;
    end
    s_tvalid <= 1'b0;

    // wait for the outstanding results, then watch for strays
    waited = 0;
    while (pending_sorted.size() != 0 && waited < LIMIT_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (pending_sorted.size() != 0) begin
      mismatches++;
      left_item = pending_sorted.pop_front();
      $display("%0t: missing result: expected value %0d, actual none", $time,
               left_item.value);
    end

    if (mismatches == 0) begin
      $display("[merge_sort_engine] OK");
    end else begin
      $display("[merge_sort_engine] ERROR");
    end
    $finish;
  end

endmodule
